// ----- hdl/dsi_pkg.sv -----
package dsi_pkg;

   localparam int VALUE_W        = 32;
   localparam int INDEX_W        = 4;
   localparam int MAX_ITEMS_DEF  = 16;
   localparam int VALUE_BITS_DEF = 32;

endpackage

// ----- hdl/dsi_if.sv -----
interface dsi_req_if import dsi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface dsi_rsp_if import dsi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] sorted_value;
   logic [INDEX_W-1:0] orig_index;
   logic               last_out;

   modport source (output valid, output sorted_value, output orig_index, output last_out,
                   input ready);
   modport sink   (input valid, input sorted_value, input orig_index, input last_out,
                   output ready);
endinterface

// ----- hdl/dsi_ram.sv -----
module dsi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/descending_sort_with_index_top.sv -----
// Channel   Direction  Transfer when        Payload
// req_ch    in         valid && ready       value, last_in
// rsp_ch    out        valid && ready       sorted_value, orig_index, last_out
//
// Loading takes one item per cycle while in the load state; the item with last_in starts the sort.
// Each result of a set is found by scanning all held values through the single
// read port of the value RAM, and is then offered on rsp_ch.
// req_ch is not ready while a set is scanned and drained.
// A stalled result holds on rsp_ch until it is taken.
// Synchronous reset empties the set and clears the emitted flags.
module descending_sort_with_index_top import dsi_pkg::*; #(
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   dsi_req_if.sink    req_ch,
   dsi_rsp_if.source  rsp_ch
);

   localparam int IDX_W  = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int VEXT_W = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam int IEXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      emitted_ff, emitted_in;
   logic [MAX_ITEMS-1:0]  done_ff, done_in;
   logic                  issue_ff, issue_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]      chk_addr_ff, chk_addr_in;
   logic                  found_ff, found_in;
   logic [VALUE_BITS-1:0] best_val_ff, best_val_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;

   logic                  full;
   logic [IDX_W-1:0]      last_addr;
   logic                  load_fire;
   logic                  rsp_fire;
   logic                  final_out;
   logic                  take;
   logic [VEXT_W-1:0]     in_ext;
   logic [VEXT_W-1:0]     out_ext;
   logic [IEXT_W-1:0]     idx_ext;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [VALUE_BITS-1:0] rd_data;

   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign last_addr = IDX_W'(count_ff - CNT_W'(1));
   assign load_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign final_out = (emitted_ff == (count_ff - CNT_W'(1)));
   assign in_ext    = VEXT_W'(req_ch.value);
   assign wr_en     = load_fire && !full;
   assign wr_addr   = count_ff[IDX_W-1:0];
   assign take      = chk_valid_ff && !done_ff[chk_addr_ff] &&
                      (!found_ff || (rd_data > best_val_ff));

   dsi_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ITEMS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_ext[VALUE_BITS-1:0]),
      .rd_en   (issue_ff),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      emitted_in   = emitted_ff;
      done_in      = done_ff;
      issue_in     = issue_ff;
      addr_in      = addr_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = chk_addr_ff;
      found_in     = found_ff;
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_fire) begin
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_ch.last_in) begin
                  state_in = ST_SCAN;
                  addr_in  = '0;
                  issue_in = 1'b1;
                  found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               chk_valid_in = 1'b1;
               chk_addr_in  = addr_ff;
               if (addr_ff == last_addr) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + IDX_W'(1);
               end
            end
            if (take) begin
               best_val_in = rd_data;
               best_idx_in = chk_addr_ff;
               found_in    = 1'b1;
            end
            if (chk_valid_ff && (chk_addr_ff == last_addr)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (final_out) begin
                  state_in   = ST_LOAD;
                  count_in   = '0;
                  emitted_in = '0;
                  done_in    = '0;
               end else begin
                  done_in[best_idx_ff] = 1'b1;
                  emitted_in = emitted_ff + CNT_W'(1);
                  state_in   = ST_SCAN;
                  addr_in    = '0;
                  issue_in   = 1'b1;
                  found_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         emitted_ff   <= '0;
         done_ff      <= '0;
         issue_ff     <= 1'b0;
         chk_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         emitted_ff   <= emitted_in;
         done_ff      <= done_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
         found_ff     <= found_in;
      end
      addr_ff     <= addr_in;
      chk_addr_ff <= chk_addr_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
   end

   assign out_ext = VEXT_W'(best_val_ff);
   assign idx_ext = IEXT_W'(best_idx_ff);

   assign req_ch.ready        = (state_ff == ST_LOAD);
   assign rsp_ch.valid        = (state_ff == ST_OUT);
   assign rsp_ch.sorted_value = out_ext[VALUE_W-1:0];
   assign rsp_ch.orig_index   = idx_ext[INDEX_W-1:0];
   assign rsp_ch.last_out     = final_out;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("Input taken while a result is offered.");

   a_emitted_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (emitted_ff < count_ff))
      else $error("More results offered than values held.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("Held count beyond capacity.");

   a_set_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_out) |=> (count_ff == '0 && done_ff == '0))
      else $error("Set not emptied after its final transfer.");

   a_pick_fresh: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !done_ff[best_idx_ff])
      else $error("Result repeats an entry already sent.");

endmodule

// ----- bench/tb_descending_sort_with_index_top.sv -----
module tb_descending_sort_with_index_top import dsi_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 64;
   localparam int PHASE_ITEMS    = 95;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last_in;
      logic               hold;
   } load_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sorted_value;
      logic [INDEX_W-1:0] orig_index;
      logic               last_out;
   } sorted_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dsi_req_if req_ch ();
   dsi_rsp_if rsp_ch ();

   descending_sort_with_index_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   load_item_type    pending_items[$];
   sorted_entry_type expected_sorted[$];
   load_item_type    next_item;

   logic [VALUE_W-1:0] held_value[MAX_ITEMS_DEF];
   int                 held_count = 0;

   int   sender_idle_pct   = 0;
   int   receiver_idle_pct = 0;
   int   mismatches        = 0;
   int   stall_cycles      = 0;
   logic load_taken        = 1'b0;

   always #2 clock = ~clock;

   task automatic emit_sorted_set();
      logic [VALUE_W-1:0] vals[MAX_ITEMS_DEF];
      logic [INDEX_W-1:0] idx[MAX_ITEMS_DEF];
      logic [VALUE_W-1:0] v;
      logic [INDEX_W-1:0] x;
      sorted_entry_type   entry;
      int                 k;
      for (int i = 0; i < held_count; i++) begin
         vals[i] = held_value[i];
         idx[i]  = INDEX_W'(i);
      end
      // Insertion sort that only moves an entry past strictly smaller values keeps
      // equal values in their arrival order.
      for (int i = 1; i < held_count; i++) begin
         v = vals[i];
         x = idx[i];
         k = i;
         while (k > 0 && vals[k-1] < v) begin
            vals[k] = vals[k-1];
            idx[k]  = idx[k-1];
            k--;
         end
         vals[k] = v;
         idx[k]  = x;
      end
      for (int i = 0; i < held_count; i++) begin
         entry.sorted_value = vals[i];
         entry.orig_index   = idx[i];
         entry.last_out     = (i == held_count - 1);
         expected_sorted.push_back(entry);
      end
      held_count = 0;
   endtask

   task automatic load_value(input logic [VALUE_W-1:0] value, input logic last_in);
      if (held_count < MAX_ITEMS_DEF) begin
         held_value[held_count] = value;
         held_count++;
      end
      if (last_in) begin
         emit_sorted_set();
      end
   endtask

   task automatic check_sorted();
      sorted_entry_type got;
      sorted_entry_type want;
      got.sorted_value = rsp_ch.sorted_value;
      got.orig_index   = rsp_ch.orig_index;
      got.last_out     = rsp_ch.last_out;
      if (expected_sorted.size() == 0) begin
         if (mismatches < MAX_REPORTS) begin
            $display("unexpected result: value %h index %0d last %b",
                     got.sorted_value, got.orig_index, got.last_out);
         end
         mismatches++;
      end else begin
         want = expected_sorted.pop_front();
         if (got !== want) begin
            if (mismatches < MAX_REPORTS) begin
               $display("mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                        want.sorted_value, want.orig_index, want.last_out,
                        got.sorted_value, got.orig_index, got.last_out);
            end
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      load_taken = 1'b0;
      if (!reset) begin
         load_taken = req_ch.valid && req_ch.ready;
         if (load_taken) begin
            load_value(req_ch.value, req_ch.last_in);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_sorted();
         end
         if (load_taken || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.value   <= '0;
         req_ch.last_in <= 1'b0;
         rsp_ch.ready   <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         if (!req_ch.valid || load_taken) begin
            if (pending_items.size() != 0 &&
                !(pending_items[0].hold && expected_sorted.size() != 0) &&
                $urandom_range(99) >= sender_idle_pct) begin
               next_item = pending_items.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.value   <= next_item.value;
               req_ch.last_in <= next_item.last_in;
            end else begin
               req_ch.valid   <= 1'b0;
               req_ch.value   <= $urandom;
               req_ch.last_in <= 1'($urandom_range(1));
            end
         end
      end
   end

   task automatic queue_load(input logic [VALUE_W-1:0] value, input logic last_in,
                             input logic hold);
      load_item_type item;
      item.value   = value;
      item.last_in = last_in;
      item.hold    = hold;
      pending_items.push_back(item);
   endtask

   task automatic queue_directed_sets();
      logic [VALUE_W-1:0] pattern;
      queue_load(32'hFFFF_FFFF, 1'b1, 1'b1);
      queue_load(32'd7, 1'b0, 1'b0);
      queue_load(32'd7, 1'b0, 1'b0);
      queue_load(32'd0, 1'b0, 1'b0);
      queue_load(32'hFFFF_FFFF, 1'b1, 1'b0);
      // Eighteen items: the last two are dropped, and the dropped final one closes the set.
      for (int i = 0; i < 18; i++) begin
         case (i % 4)
            0: pattern = 32'hAAAA_AAAA;
            1: pattern = 32'h5555_5555;
            2: pattern = 32'h0000_0000;
            default: pattern = 32'hFFFF_FFFF;
         endcase
         queue_load(pattern, i == 17, 1'b0);
      end
   endtask

   task automatic queue_random_sets(input int target);
      int                 queued;
      int                 set_len;
      int                 flavour;
      logic               hold;
      logic [VALUE_W-1:0] value;
      queued = 0;
      hold   = 1'b1;
      while (queued < target) begin
         if ($urandom_range(99) < 85) begin
            set_len = $urandom_range(16, 1);
         end else begin
            set_len = $urandom_range(22, 17);
         end
         flavour = $urandom_range(2);
         for (int i = 0; i < set_len; i++) begin
            case (flavour)
               0: value = $urandom;
               1: value = $urandom_range(7);
               default: begin
                  case ($urandom_range(3))
                     0: value = '0;
                     1: value = '1;
                     2: value = $urandom_range(3);
                     default: value = $urandom;
                  endcase
               end
            endcase
            queue_load(value, i == set_len - 1, hold && (i == 0));
         end
         queued += set_len;
         hold = ($urandom_range(5) == 0);
      end
   endtask

   task automatic wait_all_sorted();
      do begin
         @(posedge clock);
         #1;
      end while (pending_items.size() != 0 || req_ch.valid || expected_sorted.size() != 0);
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.value   = '0;
      req_ch.last_in = 1'b0;
      rsp_ch.ready   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 18;
      receiver_idle_pct = 56;
      queue_directed_sets();
      queue_random_sets(PHASE_ITEMS);
      wait_all_sorted();

      sender_idle_pct   = 56;
      receiver_idle_pct = 18;
      queue_random_sets(PHASE_ITEMS);
      wait_all_sorted();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      queue_random_sets(PHASE_ITEMS);
      wait_all_sorted();

      repeat (SETTLE_CYCLES) @(posedge clock);
      #1;
      if (mismatches == 0 && expected_sorted.size() == 0) begin
         $display("descending_sort_with_index_top test passed");
      end else begin
         $display("descending_sort_with_index_top test failed");
      end
      $finish;
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("descending_sort_with_index_top test failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/dsi_pkg.sv
hdl/dsi_if.sv
hdl/dsi_ram.sv
hdl/descending_sort_with_index_top.sv
bench/tb_descending_sort_with_index_top.sv
